// ===== hw/rtl/ryp_pkg.sv =====
// Shared constants and codes for the RGB555 to YUV packer.
package ryp_pkg;

  localparam int unsigned PixelW     = 15;
  localparam int unsigned CfgW       = 11;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned ModeW      = 2;
  localparam int unsigned PlaneW     = 2;
  localparam int unsigned RowW       = 11;
  localparam int unsigned ColW       = 12;
  localparam int unsigned DataW      = 32;
  localparam int unsigned CountW     = 3;
  localparam int unsigned SumW       = 9;
  localparam int unsigned StoreW     = 2 * SumW;
  localparam int unsigned DimW       = 13;
  localparam int unsigned QueueDepth = 4;

  // Layout modes
  localparam logic [ModeW-1:0] ModeYuy2    = 2'd0;
  localparam logic [ModeW-1:0] ModeYuy2Dbl = 2'd1;
  localparam logic [ModeW-1:0] ModeYv12    = 2'd2;
  localparam logic [ModeW-1:0] ModeYv12Dbl = 2'd3;

  // Destination planes
  localparam logic [PlaneW-1:0] PlanePacked = 2'd0;
  localparam logic [PlaneW-1:0] PlaneLuma   = 2'd1;
  localparam logic [PlaneW-1:0] PlaneU      = 2'd2;
  localparam logic [PlaneW-1:0] PlaneV      = 2'd3;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegMode   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegWidth  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegHeight = 2'd2;

  localparam logic [CfgW-1:0] ResetDim = 11'd1024;

  // Fixed-point coefficients, scaled by 2^15
  localparam logic [23:0] KYR   = 24'd8453;
  localparam logic [23:0] KYG   = 24'd16594;
  localparam logic [23:0] KYB   = 24'd3223;
  localparam logic [23:0] KYOff = 24'd524288;
  localparam logic [23:0] KUR   = 24'd4878;
  localparam logic [23:0] KUG   = 24'd9578;
  localparam logic [23:0] KUB   = 24'd14456;
  localparam logic [23:0] KCOff = 24'd4210688;
  localparam logic [23:0] KVR   = 24'd14456;
  localparam logic [23:0] KVG   = 24'd12105;
  localparam logic [23:0] KVB   = 24'd2351;

endpackage

// ===== hw/rtl/ryp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ryp_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/ryp_fifo.sv =====
// Small first-in first-out queue between the front and back parts.
module ryp_fifo #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned NW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             vld_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]    cnt_q, cnt_d;

  assign full_o = (cnt_q == NW'(DEPTH));
  assign vld_o  = (cnt_q != '0);
  assign data_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + NW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/ryp_front.sv =====
// Front part: accepts pixels, tracks position, converts to YUV, forms pair sums.
module ryp_front #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  localparam int unsigned CW = $clog2(MAX_WIDTH),
  localparam int unsigned LW = $clog2(MAX_HEIGHT),
  localparam int unsigned EntryW = ryp_pkg::ModeW + CW + LW + 32 + 2 * ryp_pkg::SumW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [ryp_pkg::ModeW-1:0]   mode_i,
  input  logic [ryp_pkg::CfgW-1:0]    line_width_i,
  input  logic [ryp_pkg::CfgW-1:0]    frame_height_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ryp_pkg::PixelW-1:0]  pixel_i,
  output logic                        push_o,
  output logic [EntryW-1:0]           push_data_o,
  input  logic                        full_i
);
  import ryp_pkg::*;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [CW-1:0]    col;
    logic [LW-1:0]    line;
  } meta_t;

  typedef struct packed {
    meta_t            meta;
    logic [7:0]       y;
    logic [7:0]       u;
    logic [7:0]       v;
    logic [7:0]       hy;
    logic [SumW-1:0]  su;
    logic [SumW-1:0]  sv;
  } entry_t;

  typedef struct packed {
    logic [23:0] yr, yg, yb;
    logic [23:0] ur, ug, ub;
    logic [23:0] vr, vg, vb;
  } prod_t;

  logic              adv, accept;
  logic              s1_vld_q, s2_vld_q, s3_vld_q;
  logic [PixelW-1:0] s1_pix_q;
  meta_t             meta_d, s1_meta_q, s2_meta_q, s3_meta_q;
  prod_t             prod_d, s2_prod_q;
  logic [23:0]       ysum, usum, vsum;
  logic [7:0]        y_d, u_d, v_d, s3_y_q, s3_u_q, s3_v_q;
  logic [7:0]        r8, g8, b8;
  logic [23:0]       held_q;
  logic [CW-1:0]     col_q, col_d;
  logic [LW-1:0]     line_q, line_d;
  logic [DimW-1:0]   eff_w, eff_h, col_nx, line_nx;
  entry_t            entry;

  // Hold the whole pipe while the last stage cannot enter the queue.
  assign adv        = !(s3_vld_q && full_i);
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;
  assign push_o     = s3_vld_q && adv;

  // Effective geometry: even, clamped to 2..max.
  always_comb begin
    eff_w = {2'b00, line_width_i[CfgW-1:1], 1'b0};
    if (eff_w < DimW'(2)) eff_w = DimW'(2);
    if (eff_w > DimW'(MAX_WIDTH)) eff_w = DimW'(MAX_WIDTH);
    eff_h = {2'b00, frame_height_i[CfgW-1:1], 1'b0};
    if (eff_h < DimW'(2)) eff_h = DimW'(2);
    if (eff_h > DimW'(MAX_HEIGHT)) eff_h = DimW'(MAX_HEIGHT);
  end

  always_comb begin
    col_nx  = DimW'(col_q) + DimW'(1);
    line_nx = DimW'(line_q) + DimW'(1);
    col_d   = CW'(col_nx);
    line_d  = line_q;
    if (col_nx >= eff_w) begin
      col_d  = '0;
      line_d = (line_nx >= eff_h) ? '0 : LW'(line_nx);
    end
  end

  assign meta_d = '{mode: mode_i, col: col_q, line: line_q};

  // Stage 2: widen channels and form the nine products.
  assign r8 = {s1_pix_q[14:10], s1_pix_q[14:12]};
  assign g8 = {s1_pix_q[9:5], s1_pix_q[9:7]};
  assign b8 = {s1_pix_q[4:0], s1_pix_q[4:2]};

  always_comb begin
    prod_d.yr = 24'(r8) * KYR;
    prod_d.yg = 24'(g8) * KYG;
    prod_d.yb = 24'(b8) * KYB;
    prod_d.ur = 24'(r8) * KUR;
    prod_d.ug = 24'(g8) * KUG;
    prod_d.ub = 24'(b8) * KUB;
    prod_d.vr = 24'(r8) * KVR;
    prod_d.vg = 24'(g8) * KVG;
    prod_d.vb = 24'(b8) * KVB;
  end

  // Stage 3: sums stay positive, so modular 24-bit arithmetic is exact.
  assign ysum = s2_prod_q.yr + s2_prod_q.yg + s2_prod_q.yb + KYOff;
  assign usum = s2_prod_q.ub + KCOff - s2_prod_q.ur - s2_prod_q.ug;
  assign vsum = s2_prod_q.vr + KCOff - s2_prod_q.vg - s2_prod_q.vb;
  assign y_d  = ysum[22:15];
  assign u_d  = usum[22:15];
  assign v_d  = vsum[22:15];

  always_comb begin
    entry.meta = s3_meta_q;
    entry.y    = s3_y_q;
    entry.u    = s3_u_q;
    entry.v    = s3_v_q;
    entry.hy   = held_q[7:0];
    entry.su   = SumW'(held_q[15:8]) + SumW'(s3_u_q);
    entry.sv   = SumW'(held_q[23:16]) + SumW'(s3_v_q);
  end

  assign push_data_o = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      col_q    <= '0;
      line_q   <= '0;
      held_q   <= '0;
    end else begin
      if (adv) begin
        s1_vld_q <= accept;
        s2_vld_q <= s1_vld_q;
        s3_vld_q <= s2_vld_q;
      end
      if (accept) begin
        col_q  <= col_d;
        line_q <= line_d;
      end
      // Even columns open a pair: hold their YUV for the odd partner.
      if (push_o && !s3_meta_q.col[0]) begin
        held_q <= {s3_v_q, s3_u_q, s3_y_q};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_pix_q  <= pixel_i;
      s1_meta_q <= meta_d;
      s2_prod_q <= prod_d;
      s2_meta_q <= s1_meta_q;
      s3_meta_q <= s2_meta_q;
      s3_y_q    <= y_d;
      s3_u_q    <= u_d;
      s3_v_q    <= v_d;
    end
  end

endmodule

// ===== hw/rtl/ryp_back.sv =====
// Back part: expands queued items into addressed byte writes, owns the line store ports.
module ryp_back #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  localparam int unsigned CW = $clog2(MAX_WIDTH),
  localparam int unsigned LW = $clog2(MAX_HEIGHT),
  localparam int unsigned Depth = MAX_WIDTH / 2,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned EntryW = ryp_pkg::ModeW + CW + LW + 32 + 2 * ryp_pkg::SumW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        head_vld_i,
  input  logic [EntryW-1:0]           head_data_i,
  output logic                        pop_o,
  output logic                        ram_we_o,
  output logic [AW-1:0]               ram_waddr_o,
  output logic [ryp_pkg::StoreW-1:0]  ram_wdata_o,
  output logic                        ram_re_o,
  output logic [AW-1:0]               ram_raddr_o,
  input  logic [ryp_pkg::StoreW-1:0]  ram_rdata_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ryp_pkg::PlaneW-1:0]  plane_o,
  output logic [ryp_pkg::RowW-1:0]    row_o,
  output logic [ryp_pkg::ColW-1:0]    byte_col_o,
  output logic [ryp_pkg::DataW-1:0]   data_o,
  output logic [ryp_pkg::CountW-1:0]  byte_count_o,
  output logic                        last_o
);
  import ryp_pkg::*;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [CW-1:0]    col;
    logic [LW-1:0]    line;
  } meta_t;

  typedef struct packed {
    meta_t            meta;
    logic [7:0]       y;
    logic [7:0]       u;
    logic [7:0]       v;
    logic [7:0]       hy;
    logic [SumW-1:0]  su;
    logic [SumW-1:0]  sv;
  } entry_t;

  entry_t            e;
  logic [1:0]        step_q;
  logic [2:0]        n_res;
  logic              odd_c, odd_l, is_last, out_load, emit, chroma_out;
  logic [31:0]       l32, c32, row32, col32;
  logic [9:0]        au_sum, av_sum;
  logic [PlaneW-1:0] plane_d;
  logic [DataW-1:0]  data_d;
  logic [CountW-1:0] cnt_d;
  logic              out_vld_q;
  logic [PlaneW-1:0] plane_q;
  logic [RowW-1:0]   row_q;
  logic [ColW-1:0]   col_q;
  logic [DataW-1:0]  data_q;
  logic [CountW-1:0] cnt_q;
  logic              last_q;

  assign e     = entry_t'(head_data_i);
  assign odd_c = e.meta.col[0];
  assign odd_l = e.meta.line[0];
  assign chroma_out = (e.meta.mode == ModeYv12) && odd_c && odd_l;

  // Number of results the head item causes.
  always_comb begin
    case (e.meta.mode)
      ModeYuy2:    n_res = odd_c ? 3'd1 : 3'd0;
      ModeYuy2Dbl: n_res = 3'd1;
      ModeYv12:    n_res = chroma_out ? 3'd3 : 3'd1;
      ModeYv12Dbl: n_res = 3'd4;
      default:     n_res = 3'd1;
    endcase
  end

  assign out_load = !out_vld_q || !out_stall_i;
  assign emit     = head_vld_i && (n_res != 3'd0) && out_load;
  assign is_last  = (3'(step_q) == n_res - 3'd1);
  // Drop items that cause no result without touching the output.
  assign pop_o    = head_vld_i && ((n_res == 3'd0) || (out_load && is_last));

  // Line store: write pair sums on even lines, fetch them on odd lines.
  assign ram_we_o    = emit && (e.meta.mode == ModeYv12) && odd_c && !odd_l;
  assign ram_waddr_o = AW'(e.meta.col >> 1);
  assign ram_wdata_o = {e.sv, e.su};
  assign ram_re_o    = emit && chroma_out && (step_q == 2'd0);
  assign ram_raddr_o = AW'(e.meta.col >> 1);

  assign au_sum = 10'(ram_rdata_i[SumW-1:0]) + 10'(e.su);
  assign av_sum = 10'(ram_rdata_i[StoreW-1:SumW]) + 10'(e.sv);

  assign l32 = 32'(e.meta.line);
  assign c32 = 32'(e.meta.col);

  always_comb begin
    plane_d = PlaneLuma;
    row32   = l32;
    col32   = c32;
    data_d  = 32'(e.y);
    cnt_d   = 3'd1;
    case (e.meta.mode)
      ModeYuy2: begin
        plane_d = PlanePacked;
        col32   = (c32 - 32'd1) << 1;
        data_d  = {e.sv[SumW-1:1], e.y, e.su[SumW-1:1], e.hy};
        cnt_d   = 3'd4;
      end
      ModeYuy2Dbl: begin
        plane_d = PlanePacked;
        col32   = c32 << 2;
        data_d  = {e.v, e.y, e.u, e.y};
        cnt_d   = 3'd4;
      end
      ModeYv12: begin
        case (step_q)
          2'd1: begin
            plane_d = PlaneU;
            row32   = l32 >> 1;
            col32   = c32 >> 1;
            data_d  = 32'(au_sum[9:2]);
          end
          2'd2: begin
            plane_d = PlaneV;
            row32   = l32 >> 1;
            col32   = c32 >> 1;
            data_d  = 32'(av_sum[9:2]);
          end
          default: begin
            plane_d = PlaneLuma;
          end
        endcase
      end
      default: begin
        case (step_q)
          2'd0: begin
            row32  = l32 << 1;
            col32  = c32 << 1;
            data_d = {16'h0000, e.y, e.y};
            cnt_d  = 3'd2;
          end
          2'd1: begin
            row32  = (l32 << 1) + 32'd1;
            col32  = c32 << 1;
            data_d = {16'h0000, e.y, e.y};
            cnt_d  = 3'd2;
          end
          2'd2: begin
            plane_d = PlaneU;
            data_d  = 32'(e.u);
          end
          default: begin
            plane_d = PlaneV;
            data_d  = 32'(e.v);
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      step_q    <= '0;
    end else begin
      if (out_load) begin
        out_vld_q <= emit;
      end
      if (pop_o) begin
        step_q <= '0;
      end else if (emit) begin
        step_q <= step_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      plane_q <= plane_d;
      row_q   <= row32[RowW-1:0];
      col_q   <= col32[ColW-1:0];
      data_q  <= data_d;
      cnt_q   <= cnt_d;
      last_q  <= is_last;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign plane_o      = plane_q;
  assign row_o        = row_q;
  assign byte_col_o   = col_q;
  assign data_o       = data_q;
  assign byte_count_o = cnt_q;
  assign last_o       = last_q;

endmodule

// ===== hw/rtl/rgb555_to_yuv_packer.sv =====
// Top level of the RGB555 to YUV packer: configuration, front, queue, back, line store.
//
// Converts a raster of RGB555 pixels to BT.601-style YUV and emits byte writes,
// each addressed by plane, row and byte column, in one of four layouts: packed
// YUY2, doubled packed YUY2, planar YV12 and doubled planar YV12. A pixel is
// taken on every cycle in which in_valid_i is high and in_stall_o is low; the
// front part runs a three-stage conversion pipe and places each pixel in a
// four-item queue, and the back part turns queued items into results through
// a single output register, one result per cycle while out_stall_i is low. The
// sustained pixel rate is therefore set by the back part, which pops a queued
// item with its last result and drops an item that has none: packed YUY2 gives
// one result on odd columns and none on even columns, doubled YUY2 one result
// per pixel, YV12 one or three results (three on odd columns of odd lines), and
// doubled YV12 four. The first result of a pixel passes through the three pipe
// stages, the queue and the output register before it reaches the outputs.
// Chroma averaging in YV12 uses a line store of MAX_WIDTH/2 entries of 18 bits
// (a RAM with registered read); it has no clearing pass and holds nothing valid
// until an even line has been written in YV12 mode. Write the configuration
// registers only while the block is idle; a new geometry takes effect at the
// next pixel, and the position counters keep running across mode changes.
module rgb555_to_yuv_packer #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ryp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ryp_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ryp_pkg::PixelW-1:0]   pixel_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ryp_pkg::PlaneW-1:0]   plane_o,
  output logic [ryp_pkg::RowW-1:0]     row_o,
  output logic [ryp_pkg::ColW-1:0]     byte_col_o,
  output logic [ryp_pkg::DataW-1:0]    data_o,
  output logic [ryp_pkg::CountW-1:0]   byte_count_o,
  output logic                         last_o
);
  import ryp_pkg::*;

  localparam int unsigned CW     = $clog2(MAX_WIDTH);
  localparam int unsigned LW     = $clog2(MAX_HEIGHT);
  localparam int unsigned Depth  = MAX_WIDTH / 2;
  localparam int unsigned AW     = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned EntryW = ModeW + CW + LW + 32 + 2 * SumW;

  logic [ModeW-1:0]  mode_q;
  logic [CfgW-1:0]   width_q;
  logic [CfgW-1:0]   height_q;

  logic              q_push, q_full, q_pop, q_vld;
  logic [EntryW-1:0] q_push_data, q_head;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [StoreW-1:0] ram_wdata, ram_rdata;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeYuy2;
      width_q  <= ResetDim;
      height_q <= ResetDim;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegMode:   mode_q   <= cfg_data_i[ModeW-1:0];
        RegWidth:  width_q  <= cfg_data_i;
        RegHeight: height_q <= cfg_data_i;
        default: begin
          mode_q <= mode_q;
        end
      endcase
    end
  end

  // Front: accept, count position, convert, pair up.
  ryp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (mode_q),
    .line_width_i   (width_q),
    .frame_height_i (height_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_i        (pixel_i),
    .push_o         (q_push),
    .push_data_o    (q_push_data),
    .full_i         (q_full)
  );

  // Queue decouples conversion from result expansion.
  ryp_fifo #(
    .WIDTH (EntryW),
    .DEPTH (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .vld_o       (q_vld),
    .data_o      (q_head)
  );

  // Back: expand each item into its results.
  ryp_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_vld_i   (q_vld),
    .head_data_i  (q_head),
    .pop_o        (q_pop),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .plane_o      (plane_o),
    .row_o        (row_o),
    .byte_col_o   (byte_col_o),
    .data_o       (data_o),
    .byte_count_o (byte_count_o),
    .last_o       (last_o)
  );

  // Chroma pair sums of the previous even line.
  ryp_ram #(
    .WIDTH (StoreW),
    .DEPTH (Depth)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The front must never push into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_full |-> !q_push)
    else $error("queue overflow");

  // Packed words always carry four bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && plane_o == PlanePacked) |-> (byte_count_o == 3'd4))
    else $error("packed word with partial byte count");

  // A U byte is never marked last: its V byte from the same pixel follows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && plane_o == PlaneU) |-> !last_o)
    else $error("U result marked last");

  // The line store is never read and written in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ram_we && ram_re))
    else $error("line store read and write collide");

endmodule

// ===== tb/sv/rgb555_to_yuv_packer_tb.sv =====
// Self-checking testbench for the RGB555 to YUV packer: directed tests, then random traffic.
module rgb555_to_yuv_packer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ryp_pkg::*;

  localparam int unsigned MaxWidth     = 1024;
  localparam int unsigned MaxHeight    = 1024;
  localparam int unsigned StoreDepth   = MaxWidth / 2;
  // Cycles to let pass after the last expected write before touching the
  // registers: covers the pipe latency when the last item made no write.
  localparam int unsigned SettleCycles = 16;
  // Cycles in a row with no item moved on either side before giving up.
  localparam int unsigned IdleLimit    = 1000;
  localparam int unsigned RandomPixels = 220;
  // Register index outside the map; the block must ignore writes to it.
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

  typedef struct packed {
    logic [PlaneW-1:0] plane;
    logic [RowW-1:0]   row;
    logic [ColW-1:0]   byte_col;
    logic [DataW-1:0]  data;
    logic [CountW-1:0] byte_count;
    logic              last;
  } byte_write_t;

  typedef struct packed {
    logic [7:0] v;
    logic [7:0] u;
    logic [7:0] y;
  } yuv_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgW-1:0]     cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [PixelW-1:0]   pixel_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [PlaneW-1:0]   plane_o;
  logic [RowW-1:0]     row_o;
  logic [ColW-1:0]     byte_col_o;
  logic [DataW-1:0]    data_o;
  logic [CountW-1:0]   byte_count_o;
  logic                last_o;

  rgb555_to_yuv_packer #(
    .MAX_WIDTH (MaxWidth),
    .MAX_HEIGHT(MaxHeight)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_i     (pixel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .plane_o     (plane_o),
    .row_o       (row_o),
    .byte_col_o  (byte_col_o),
    .data_o      (data_o),
    .byte_count_o(byte_count_o),
    .last_o      (last_o)
  );

  // Mirror of the block: registers, raster position, held pixel, line store.
  logic [ModeW-1:0]  cur_mode;
  logic [CfgW-1:0]   cur_width;
  logic [CfgW-1:0]   cur_height;
  int unsigned       col_pos;
  int unsigned       line_pos;
  yuv_t              held_pix;
  logic [StoreW-1:0] pair_sums [StoreDepth];

  byte_write_t expected_writes[$];
  int unsigned errors;
  int unsigned burst_left;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [7:0] widen5(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

  // Fixed-point BT.601 conversion; every sum is positive, so bits 22:15
  // are the shifted and truncated byte.
  function automatic yuv_t rgb_to_yuv(input logic [PixelW-1:0] pix);
    int   r, g, b, acc;
    yuv_t res;
    r = int'(widen5(pix[14:10]));
    g = int'(widen5(pix[9:5]));
    b = int'(widen5(pix[4:0]));
    acc = int'(KYR) * r + int'(KYG) * g + int'(KYB) * b + int'(KYOff);
    res.y = acc[22:15];
    acc = int'(KCOff) + int'(KUB) * b - int'(KUR) * r - int'(KUG) * g;
    res.u = acc[22:15];
    acc = int'(KCOff) + int'(KVR) * r - int'(KVG) * g - int'(KVB) * b;
    res.v = acc[22:15];
    return res;
  endfunction

  // Drop bit 0, then clamp to 2..limit.
  function automatic int unsigned clamp_dim(input logic [CfgW-1:0] val,
                                            input int unsigned limit);
    int unsigned d;
    d = int'(val) & 32'hFFFF_FFFE;
    if (d < 2) d = 2;
    if (d > limit) d = limit;
    return d;
  endfunction

  function automatic byte_write_t make_write(input logic [PlaneW-1:0] plane,
                                             input int unsigned row,
                                             input int unsigned col,
                                             input logic [DataW-1:0] data,
                                             input logic [CountW-1:0] count);
    byte_write_t w;
    w.plane      = plane;
    w.row        = row[RowW-1:0];
    w.byte_col   = col[ColW-1:0];
    w.data       = data;
    w.byte_count = count;
    w.last       = 1'b0;
    return w;
  endfunction

  // Work out the writes one pixel causes, queue them, advance the mirror.
  function automatic void plan_writes(input logic [PixelW-1:0] pix);
    yuv_t              p;
    byte_write_t       batch [4];
    int                n;
    bit                odd_col;
    int unsigned       slot;
    logic [SumW-1:0]   su, sv;
    logic [SumW:0]     tot_u, tot_v;
    logic [StoreW-1:0] entry;
    p       = rgb_to_yuv(pix);
    n       = 0;
    odd_col = col_pos[0];
    slot    = (col_pos >> 1) % StoreDepth;
    su      = SumW'(held_pix.u) + SumW'(p.u);
    sv      = SumW'(held_pix.v) + SumW'(p.v);
    case (cur_mode)
      ModeYuy2: begin
        if (odd_col) begin
          batch[n++] = make_write(PlanePacked, line_pos, (col_pos - 1) * 2,
                                  {sv[8:1], p.y, su[8:1], held_pix.y}, 3'd4);
        end
      end
      ModeYuy2Dbl: begin
        batch[n++] = make_write(PlanePacked, line_pos, col_pos * 4,
                                {p.v, p.y, p.u, p.y}, 3'd4);
      end
      ModeYv12: begin
        batch[n++] = make_write(PlaneLuma, line_pos, col_pos, {24'd0, p.y}, 3'd1);
        if (odd_col) begin
          if (!line_pos[0]) begin
            pair_sums[slot] = {sv, su};
          end else begin
            entry = pair_sums[slot];
            tot_u = {1'b0, entry[SumW-1:0]} + {1'b0, su};
            tot_v = {1'b0, entry[StoreW-1:SumW]} + {1'b0, sv};
            batch[n++] = make_write(PlaneU, line_pos >> 1, col_pos >> 1,
                                    {24'd0, tot_u[SumW:2]}, 3'd1);
            batch[n++] = make_write(PlaneV, line_pos >> 1, col_pos >> 1,
                                    {24'd0, tot_v[SumW:2]}, 3'd1);
          end
        end
      end
      default: begin
        batch[n++] = make_write(PlaneLuma, line_pos * 2, col_pos * 2,
                                {16'd0, p.y, p.y}, 3'd2);
        batch[n++] = make_write(PlaneLuma, line_pos * 2 + 1, col_pos * 2,
                                {16'd0, p.y, p.y}, 3'd2);
        batch[n++] = make_write(PlaneU, line_pos, col_pos, {24'd0, p.u}, 3'd1);
        batch[n++] = make_write(PlaneV, line_pos, col_pos, {24'd0, p.v}, 3'd1);
      end
    endcase
    if (n > 0) batch[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_writes.push_back(batch[i]);

    if (!odd_col) held_pix = p;
    col_pos++;
    if (col_pos >= clamp_dim(cur_width, MaxWidth)) begin
      col_pos = 0;
      line_pos++;
      if (line_pos >= clamp_dim(cur_height, MaxHeight)) line_pos = 0;
    end
  endfunction

  function automatic logic [PixelW-1:0] random_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 15'h7C00;
      3:       return 15'h03E0;
      4:       return 15'h001F;
      default: return 15'($urandom_range(0, 32767));
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // Offer one item in bursts with random gaps; hold it until taken, then
  // predict what it causes.
  task automatic send_pixel(input logic [PixelW-1:0] pix);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    pixel_i    <= pix;
    do @(posedge clk_i); while (in_stall_o);
    plan_writes(pix);
  endtask

  // Stop offering items and wait until every expected write is out, then
  // give the pipe time to finish any item that makes no write.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Call only while idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegMode:   cur_mode   = val[ModeW-1:0];
      RegWidth:  cur_width  = val;
      RegHeight: cur_height = val;
      default: ;
    endcase
  endtask

  // Drain, then program a layout. Planar YV12 reads the line store on odd
  // lines, so first walk to the start of an even line in doubled YUY2 with
  // the narrowest line: every store entry is then written before it is read.
  task automatic set_layout(input logic [ModeW-1:0] mode, input logic [CfgW-1:0] width,
                            input logic [CfgW-1:0] height);
    wait_idle();
    if (mode == ModeYv12) begin
      write_reg(RegMode, ModeYuy2Dbl);
      write_reg(RegWidth, 11'd2);
      while (col_pos != 0 || line_pos[0]) send_pixel(random_pixel());
      wait_idle();
    end
    write_reg(RegMode, mode);
    write_reg(RegWidth, width);
    write_reg(RegHeight, height);
  endtask

  // Reset defaults: packed YUY2 on a 1024 x 1024 frame.
  task automatic test_reset_state();
    send_pixel(15'h7FFF);
    send_pixel(15'h0000);
    send_pixel(15'h7C00);
    send_pixel(15'h001F);
  endtask

  // One word per pixel: black, white, each primary, alternating bits.
  task automatic test_color_extremes();
    set_layout(ModeYuy2Dbl, 11'd2, 11'd2);
    send_pixel(15'h0000);
    send_pixel(15'h7FFF);
    send_pixel(15'h7C00);
    send_pixel(15'h03E0);
    send_pixel(15'h001F);
    send_pixel(15'h2AAA);
  endtask

  // One full 2 x 2 frame: luma every pixel, chroma on the odd line.
  task automatic test_planar_block();
    set_layout(ModeYv12, 11'd2, 11'd2);
    send_pixel(15'h7FFF);
    send_pixel(15'h0000);
    send_pixel(15'h7C00);
    send_pixel(15'h001F);
  endtask

  // Doubled planar with all-ones geometry, clamped to the maximum.
  task automatic test_doubled_planar();
    set_layout(ModeYv12Dbl, 11'h7FF, 11'h7FF);
    send_pixel(15'h5555);
    send_pixel(15'h7FFF);
  endtask

  // Geometry below range, an odd width, and a write to an unmapped index.
  task automatic test_geometry_clamp();
    set_layout(ModeYuy2Dbl, 11'd0, 11'd1);
    repeat (4) send_pixel(random_pixel());
    wait_idle();
    write_reg(RegWidth, 11'd3);
    write_reg(RegSpare, 11'h7FF);
    send_pixel(15'h03E0);
    send_pixel(15'h7C1F);
  endtask

  // Change mode and width mid-line: a YUY2 pair uses whatever pixel was held.
  task automatic test_midline_switch();
    set_layout(ModeYuy2Dbl, 11'd6, 11'd4);
    send_pixel(15'h7C00);
    wait_idle();
    write_reg(RegMode, ModeYuy2);
    send_pixel(15'h001F);
    wait_idle();
    write_reg(RegMode, ModeYv12Dbl);
    send_pixel(15'h03E0);
    wait_idle();
    write_reg(RegWidth, 11'd4);
    send_pixel(15'h7FFF);
  endtask

  // Segments of random layout and geometry; mostly small frames, now and
  // then out-of-range or widest geometry.
  task automatic test_random_traffic();
    int unsigned       sent, seg, eff_w;
    logic [ModeW-1:0]  mode;
    logic [CfgW-1:0]   width, height;
    sent = 0;
    while (sent < RandomPixels) begin
      mode = ModeW'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0:       width = CfgW'($urandom_range(0, 2047));
        1:       width = ($urandom_range(0, 1) == 0) ? 11'h7FF : 11'd1024;
        default: width = CfgW'(2 * $urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 7))
        0:       height = CfgW'($urandom_range(0, 2047));
        default: height = CfgW'(2 * $urandom_range(1, 4));
      endcase
      eff_w = clamp_dim(width, MaxWidth);
      if (eff_w > 64) seg = $urandom_range(4, 16);
      else if (mode == ModeYv12 && eff_w <= 16) seg = 2 * eff_w * $urandom_range(1, 2);
      else seg = $urandom_range(12, 40);
      set_layout(mode, width, height);
      for (int i = 0; i < seg; i++) begin
        send_pixel(random_pixel());
        // Hold off now and then until the block has drained.
        if ($urandom_range(0, 59) == 0) wait_idle();
      end
      sent += seg;
    end
  endtask

  // Receiver: stall in phases of none, random, two-in-three and long runs.
  initial begin : stall_pattern
    int unsigned kind, left, tick;
    out_stall_i = 1'b0;
    kind = 0;
    left = 0;
    tick = 0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        kind = $urandom_range(0, 3);
        left = $urandom_range(10, 60);
        tick = 0;
      end
      left--;
      tick++;
      case (kind)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 99) < 40);
        2:       out_stall_i <= (tick % 3 != 0);
        default: out_stall_i <= (tick % 8 < 5);
      endcase
    end
  end

  // Check each write taken against the oldest expectation.
  always @(posedge clk_i) begin : check_writes
    byte_write_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_writes.size() == 0) begin
        $error("write with nothing expected: plane %0d row %0d byte_col %0d data %08h",
               plane_o, row_o, byte_col_o, data_o);
        errors++;
      end else begin
        want = expected_writes.pop_front();
        check_field("plane", 32'(want.plane), 32'(plane_o));
        check_field("row", 32'(want.row), 32'(row_o));
        check_field("byte_col", 32'(want.byte_col), 32'(byte_col_o));
        check_field("data", want.data, data_o);
        check_field("byte_count", 32'(want.byte_count), 32'(byte_count_o));
        check_field("last", 32'(want.last), 32'(last_o));
      end
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("FAIL rgb555_to_yuv_packer");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = RegMode;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    pixel_i     = '0;
    errors      = 0;
    burst_left  = 0;
    cur_mode    = ModeYuy2;
    cur_width   = ResetDim;
    cur_height  = ResetDim;
    col_pos     = 0;
    line_pos    = 0;
    held_pix    = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_color_extremes();
    test_planar_block();
    test_doubled_planar();
    test_geometry_clamp();
    test_midline_switch();
    test_random_traffic();

    wait_idle();
    if (errors == 0) begin
      $display("PASS rgb555_to_yuv_packer");
    end else begin
      $display("FAIL rgb555_to_yuv_packer");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ryp_pkg.sv
hw/rtl/ryp_ram.sv
hw/rtl/ryp_fifo.sv
hw/rtl/ryp_front.sv
hw/rtl/ryp_back.sv
hw/rtl/rgb555_to_yuv_packer.sv
tb/sv/rgb555_to_yuv_packer_tb.sv
